[rtl/mtc_pkg.sv]
package mtc_pkg;

	// Table geometry: number of slots and identifier width.
	localparam int Slots  = 16;
	localparam int IdBits = 16;
	localparam int IdxW   = $clog2(Slots);
	localparam int CountW = 5;
	localparam int AddrW  = 3;

	// Register index of the capacity register (paddr[2]).
	localparam logic RegMaxMembers = 1'b0;

	// Capacity after reset.
	localparam logic [CountW-1:0] MaxMembersReset = CountW'(16);

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_QUERY  = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_FULL       = 2'd1,
		ST_EMPTY      = 2'd2,
		ST_NOT_MEMBER = 2'd3
	} status_t;

	typedef enum logic {
		CTL_IDLE = 1'b0,
		CTL_EXEC = 1'b1
	} ctl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage

[rtl/mtc_ifs.sv]
// Request channel: one action word per handshake.
interface mtc_req_if;
	logic                          valid;
	logic                          ready;
	mtc_pkg::action_t              action;
	logic [mtc_pkg::IdBits-1:0]    client_id;

	modport source (output valid, output action, output client_id, input ready);
	modport sink   (input valid, input action, input client_id, output ready);
endinterface

// Response channel: one result word per handshake.
interface mtc_rsp_if;
	logic                          valid;
	logic                          ready;
	mtc_pkg::status_t              status;
	logic                          is_member;
	logic [mtc_pkg::CountW-1:0]    member_count;
	logic                          list_empty;

	modport source (output valid, output status, output is_member, output member_count,
		output list_empty, input ready);
	modport sink   (input valid, input status, input is_member, input member_count,
		input list_empty, output ready);
endinterface

[rtl/mtc_ctrl.sv]
module mtc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output mtc_pkg::cmd_t  cmd
);

	mtc_pkg::ctl_state_t state_q, state_d;
	logic                rsp_valid_q;
	logic                out_free;

	// The output register can take a new result when empty or being drained.
	assign out_free = !rsp_valid_q || rsp_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mtc_pkg::CTL_IDLE: begin
				if (req_valid) state_d = mtc_pkg::CTL_EXEC;
			end
			mtc_pkg::CTL_EXEC: begin
				if (out_free) state_d = mtc_pkg::CTL_IDLE;
			end
			default: state_d = mtc_pkg::CTL_IDLE;
		endcase
	end

	// Outputs and datapath commands.
	always_comb begin
		req_ready = 1'b0;
		cmd       = '0;
		unique case (state_q)
			mtc_pkg::CTL_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			mtc_pkg::CTL_EXEC: begin
				cmd.exec = out_free;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	// State and result-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mtc_pkg::CTL_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

[rtl/mtc_dp.sv]
module mtc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mtc_pkg::cmd_t                 cmd,
	input  mtc_pkg::action_t              req_action,
	input  logic [mtc_pkg::IdBits-1:0]    req_client_id,
	input  logic                          cfg_wr,
	input  logic                          cfg_sel,
	input  logic [mtc_pkg::CountW-1:0]    cfg_wdata,
	output logic [mtc_pkg::CountW-1:0]    cfg_rdata,
	output mtc_pkg::status_t              rsp_status,
	output logic                          rsp_is_member,
	output logic [mtc_pkg::CountW-1:0]    rsp_member_count,
	output logic                          rsp_list_empty
);

	// Captured request word.
	mtc_pkg::action_t                  act_q;
	logic [mtc_pkg::IdBits-1:0]        id_q;

	// Member list and its count; slots at and above the count never match.
	logic [mtc_pkg::IdBits-1:0]        slots_q [mtc_pkg::Slots];
	logic [mtc_pkg::CountW-1:0]        cnt_q;
	logic [mtc_pkg::CountW-1:0]        cap_q;

	// Result register.
	mtc_pkg::status_t                  status_q;
	logic                              member_q;
	logic [mtc_pkg::CountW-1:0]        count_q;
	logic                              empty_q;

	logic [mtc_pkg::Slots-1:0]         hit;
	logic [mtc_pkg::Slots-1:0]         first_hit;
	logic [mtc_pkg::Slots-1:0]         from_hit;
	logic                              present;
	logic [mtc_pkg::CountW-1:0]        cap_eff;
	logic                              full;
	logic                              add_go;
	logic                              rem_go;
	mtc_pkg::status_t                  status_d;
	logic                              member_d;
	logic [mtc_pkg::CountW-1:0]        cnt_d;

	// Compare every occupied slot against the identifier in parallel.
	always_comb begin
		for (int i = 0; i < mtc_pkg::Slots; i++) begin
			hit[i] = (slots_q[i] == id_q) && (mtc_pkg::CountW'(i) < cnt_q);
		end
	end

	// Isolate the first match and mark it and every slot above it.
	assign present   = |hit;
	assign first_hit = hit & (~hit + mtc_pkg::Slots'(1));
	assign from_hit  = ~(first_hit - mtc_pkg::Slots'(1));

	// Capacity is saturated to the table size.
	assign cap_eff = (cap_q > mtc_pkg::CountW'(mtc_pkg::Slots)) ?
		mtc_pkg::CountW'(mtc_pkg::Slots) : cap_q;
	assign full    = cnt_q >= cap_eff;

	// Decide the action outcome.
	always_comb begin
		status_d = mtc_pkg::ST_OK;
		member_d = present;
		cnt_d    = cnt_q;
		add_go   = 1'b0;
		rem_go   = 1'b0;
		unique case (act_q)
			mtc_pkg::ACT_ADD: begin
				if (full) begin
					status_d = mtc_pkg::ST_FULL;
				end else begin
					add_go = 1'b1;
					cnt_d  = cnt_q + mtc_pkg::CountW'(1);
				end
			end
			mtc_pkg::ACT_REMOVE: begin
				if (cnt_q == '0) begin
					status_d = mtc_pkg::ST_EMPTY;
				end else if (!present) begin
					status_d = mtc_pkg::ST_NOT_MEMBER;
				end else begin
					rem_go = 1'b1;
					cnt_d  = cnt_q - mtc_pkg::CountW'(1);
				end
			end
			mtc_pkg::ACT_QUERY: begin
				status_d = mtc_pkg::ST_OK;
			end
			mtc_pkg::ACT_CLEAR: begin
				cnt_d    = '0;
				member_d = 1'b0;
			end
			default: begin
				status_d = mtc_pkg::ST_OK;
			end
		endcase
	end

	// Request capture and result register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= req_action;
			id_q  <= req_client_id;
		end
		if (cmd.exec) begin
			status_q <= status_d;
			member_q <= member_d;
			count_q  <= cnt_d;
			empty_q  <= (cnt_d == '0);
		end
	end

	// Slot storage: append at the count, or shift later entries down one slot.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (add_go) slots_q[cnt_q[mtc_pkg::IdxW-1:0]] <= id_q;
			if (rem_go) begin
				for (int i = 0; i < mtc_pkg::Slots - 1; i++) begin
					if (from_hit[i]) slots_q[i] <= slots_q[i+1];
				end
			end
		end
	end

	// Count and capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			cap_q <= mtc_pkg::MaxMembersReset;
		end else begin
			if (cmd.exec) cnt_q <= cnt_d;
			if (cfg_wr && (cfg_sel == mtc_pkg::RegMaxMembers)) cap_q <= cfg_wdata;
		end
	end

	assign cfg_rdata        = (cfg_sel == mtc_pkg::RegMaxMembers) ? cap_q : '0;
	assign rsp_status       = status_q;
	assign rsp_is_member    = member_q;
	assign rsp_member_count = count_q;
	assign rsp_list_empty   = empty_q;

endmodule

[rtl/membership_table_compacting_unit.sv]
// Channel | Direction | Word
// req     | in        | action, client_id
// rsp     | out       | status, is_member, member_count, list_empty
// apb     | in        | capacity register max_members at byte address 0
//
// A request is captured in the idle state, then in the execute step the
// parallel compare over all slots, the first-match pick and the one-step shift
// of the list all complete. The result then sits in an output register while
// the next request is accepted. A stalled response holds the engine in its
// execute step until the output register frees. arst_n clears the count,
// the handshake state and restores the capacity to 16; no clearing pass runs.
module membership_table_compacting_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	mtc_req_if.sink                      req,
	mtc_rsp_if.source                    rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mtc_pkg::AddrW-1:0]    paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	mtc_pkg::cmd_t              cmd;
	logic                       req_ready;
	logic                       rsp_valid;
	logic                       cfg_wr;
	logic [mtc_pkg::CountW-1:0] cfg_rdata;
	mtc_pkg::status_t           rsp_status;
	logic                       rsp_is_member;
	logic [mtc_pkg::CountW-1:0] rsp_member_count;
	logic                       rsp_list_empty;

	// Register access completes in the access phase; no wait states.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = {{(32 - mtc_pkg::CountW){1'b0}}, cfg_rdata};

	mtc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	mtc_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.req_action       (req.action),
		.req_client_id    (req.client_id),
		.cfg_wr           (cfg_wr),
		.cfg_sel          (paddr[2]),
		.cfg_wdata        (pwdata[mtc_pkg::CountW-1:0]),
		.cfg_rdata        (cfg_rdata),
		.rsp_status       (rsp_status),
		.rsp_is_member    (rsp_is_member),
		.rsp_member_count (rsp_member_count),
		.rsp_list_empty   (rsp_list_empty)
	);

	assign req.ready        = req_ready;
	assign rsp.valid        = rsp_valid;
	assign rsp.status       = rsp_status;
	assign rsp.is_member    = rsp_is_member;
	assign rsp.member_count = rsp_member_count;
	assign rsp.list_empty   = rsp_list_empty;

endmodule

[rtl/mtc_checker.sv]
module mtc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input mtc_pkg::status_t              rsp_status,
	input logic                          rsp_is_member,
	input logic [mtc_pkg::CountW-1:0]    rsp_member_count,
	input logic                          rsp_list_empty
);

	// A pending result word stays offered until taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped before it was taken");

	// The empty flag agrees with the count.
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_list_empty == (rsp_member_count == '0)))
		else $error("list_empty disagrees with member_count");

	// The count never exceeds the table size.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_member_count <= mtc_pkg::CountW'(mtc_pkg::Slots)))
		else $error("member_count beyond table size");

	// A remove from an empty list leaves it empty and finds nothing.
	a_empty_remove: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == mtc_pkg::ST_EMPTY) |->
			rsp_list_empty && !rsp_is_member)
		else $error("empty status with members present");

	// A not-member status never comes with a membership hit.
	a_not_member: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == mtc_pkg::ST_NOT_MEMBER) |-> !rsp_is_member)
		else $error("not-member status with is_member set");

endmodule

bind membership_table_compacting_unit mtc_checker u_mtc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_is_member    (rsp.is_member),
	.rsp_member_count (rsp.member_count),
	.rsp_list_empty   (rsp.list_empty)
);
